// ===== rtl/eod_pkg.sv =====
// Shared constants, types and helpers for the elevator dispatch table.
`default_nettype none
package eod_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int DIST_W = 6;

  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_REMOVE   = 3'd1;
  localparam logic [2:0] CMD_SET_LOC  = 3'd2;
  localparam logic [2:0] CMD_SET_DST  = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_ANY_DST  = 3'd5;
  localparam logic [2:0] CMD_OTHER_AT = 3'd6;
  localparam logic [2:0] CMD_TAKE     = 3'd7;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_PRESENT = 2'd3;

  localparam logic [4:0] FLOOR_NONE = 5'h1F;  // -1
  localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(32);  // above any real distance

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic [2:0]        cmd;
    logic [31:0]       key;
    logic [4:0]        fv;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [4:0]        loc;
    logic [4:0]        dst;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              any_dst;
    logic              other_at;
    logic [DIST_W-1:0] dmin;
    logic              tie;   // an idle car at dmin has a lower address than key
  } eod_tok_t;

  // Table update broadcast at the end of a scan.
  typedef struct packed {
    logic             we;
    logic [2:0]       cmd;
    logic [IDX_W-1:0] idx;
    logic [31:0]      key;
    logic [4:0]       fv;
  } eod_commit_t;

  // |a - b| for two 5-bit signed floors.
  function automatic logic [DIST_W-1:0] floor_dist(input logic [4:0] a, input logic [4:0] b);
    logic [DIST_W-1:0] d;
    d = {a[4], a} - {b[4], b};
    return d[DIST_W-1] ? (~d + DIST_W'(1)) : d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/eod_req_if.sv =====
// Command channel: valid/ready plus one command transaction.
`default_nettype none
interface eod_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [31:0]       car_address;
  logic signed [4:0] floor_value;

  modport source (output valid, cmd, car_address, floor_value, input ready);
  modport sink   (input valid, cmd, car_address, floor_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/eod_rsp_if.sv =====
// Result channel: valid/ready plus one result transaction.
`default_nettype none
interface eod_rsp_if;
  logic              valid;
  logic              ready;
  logic              answer;
  logic              found;
  logic signed [4:0] car_location;
  logic signed [4:0] car_destination;
  logic [1:0]        status;

  modport source (output valid, answer, found, car_location, car_destination, status,
                  input ready);
  modport sink   (input valid, answer, found, car_location, car_destination, status,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/elevator_order_dispatch_table.sv =====
// Elevator dispatch table: one command transaction scanned along a row of entry cells.
// The token passes every cell in turn, then the result is registered and offered.
// A new command is taken only when no scan is running, at the earliest in the
// cycle its predecessor's result is taken. The scan token moves one cell per cycle.
// Reset clears all entry valid bits and the control FSM; no clearing pass is needed.
`default_nettype none
module elevator_order_dispatch_table (
  input wire logic clk,
  input wire logic rst,
  eod_req_if.sink   request,
  eod_rsp_if.source response
);
  import eod_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             req_take;
  logic             scan_done;

  eod_tok_t    head;
  eod_tok_t    tok [TABLE_ENTRIES+1];
  eod_tok_t    last;
  eod_commit_t commit;

  logic              answer_next;
  logic [4:0]        loc_next;
  logic [4:0]        dst_next;
  logic [1:0]        status_next;
  logic [DIST_W-1:0] mine;

  logic              answer;
  logic              found;
  logic [4:0]        loc_out;
  logic [4:0]        dst_out;
  logic [1:0]        status;

  assign request.ready = (state == ST_IDLE) || (state == ST_OUT && response.ready);
  assign req_take      = request.valid && request.ready;
  assign scan_done     = (state == ST_SCAN) && (cnt == CNT_W'(TABLE_ENTRIES));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_take) state_next = ST_SCAN;
      ST_SCAN: if (scan_done) state_next = ST_OUT;
      ST_OUT: begin
        if (req_take) state_next = ST_SCAN;
        else if (response.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (req_take) cnt <= '0;
      else if (state == ST_SCAN && !scan_done) cnt <= cnt + CNT_W'(1);
    end
  end

  // head of the chain: fresh token per command
  always_ff @(posedge clk) begin
    if (req_take) begin
      head.cmd        <= request.cmd;
      head.key        <= request.car_address;
      head.fv         <= request.floor_value;
      head.found      <= 1'b0;
      head.idx        <= '0;
      head.loc        <= FLOOR_NONE;
      head.dst        <= FLOOR_NONE;
      head.free_found <= 1'b0;
      head.free_idx   <= '0;
      head.any_dst    <= 1'b0;
      head.other_at   <= 1'b0;
      head.dmin       <= DIST_NONE;
      head.tie        <= 1'b0;
    end
  end

  assign tok[0] = head;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    eod_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(g)),
      .commit     (commit),
      .tok_in     (tok[g]),
      .tok_out    (tok[g+1])
    );
  end

  assign last = tok[TABLE_ENTRIES];
  assign mine = floor_dist(last.found ? last.loc : FLOOR_NONE, last.fv);

  always_comb begin
    answer_next = 1'b0;
    loc_next    = FLOOR_NONE;
    dst_next    = FLOOR_NONE;
    status_next = STAT_OK;
    commit.we   = 1'b0;
    commit.cmd  = last.cmd;
    commit.idx  = last.idx;
    commit.key  = last.key;
    commit.fv   = last.fv;
    unique case (last.cmd)
      CMD_ADD: begin
        commit.idx = last.free_idx;
        if (last.found) begin
          status_next = STAT_PRESENT;
        end else if (!last.free_found) begin
          status_next = STAT_FULL;
        end else begin
          commit.we = scan_done;
        end
      end
      CMD_REMOVE, CMD_SET_LOC, CMD_SET_DST: begin
        if (!last.found) status_next = STAT_MISSING;
        else commit.we = scan_done;
      end
      CMD_READ: begin
        if (!last.found) begin
          status_next = STAT_MISSING;
        end else begin
          loc_next = last.loc;
          dst_next = last.dst;
        end
      end
      CMD_ANY_DST:  answer_next = last.any_dst;
      CMD_OTHER_AT: answer_next = last.other_at;
      CMD_TAKE: begin
        answer_next = !((last.dmin < mine) || (last.dmin == mine && last.tie));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      answer  <= answer_next;
      found   <= last.found;
      loc_out <= loc_next;
      dst_out <= dst_next;
      status  <= status_next;
    end
  end

  assign response.valid           = (state == ST_OUT);
  assign response.answer          = answer;
  assign response.found           = found;
  assign response.car_location    = loc_out;
  assign response.car_destination = dst_out;
  assign response.status          = status;

  a_commit_at_end: assert property (@(posedge clk) disable iff (rst)
    commit.we |-> scan_done)
    else $error("table update outside end of scan");

  a_result_follows_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |=> response.valid)
    else $error("result not presented after scan");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    req_take |=> (state == ST_SCAN && cnt == '0))
    else $error("accepted command did not start a scan");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (response.valid && response.status == STAT_FULL) |-> !response.found)
    else $error("table full reported for a present key");

endmodule
`default_nettype wire

// ===== rtl/eod_cell.sv =====
// One table entry: folds its contents into the passing scan token and takes updates.
`default_nettype none
module eod_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [eod_pkg::IDX_W-1:0] cell_index,
  input  wire eod_pkg::eod_commit_t      commit,
  input  wire eod_pkg::eod_tok_t         tok_in,
  output eod_pkg::eod_tok_t              tok_out
);
  import eod_pkg::*;

  logic        valid;
  logic [31:0] addr;
  logic [4:0]  loc;
  logic [4:0]  dst;

  eod_tok_t          tok_next;
  logic              hit;
  logic [DIST_W-1:0] d;
  logic              lower;

  always_comb begin
    tok_next = tok_in;
    hit      = valid && (addr == tok_in.key);
    d        = floor_dist(loc, tok_in.fv);
    lower    = addr < tok_in.key;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.idx   = cell_index;
      tok_next.loc   = loc;
      tok_next.dst   = dst;
    end
    if (!tok_in.free_found && !valid) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = cell_index;
    end
    if (valid && dst == tok_in.fv) tok_next.any_dst = 1'b1;
    if (valid && loc == tok_in.fv && !(addr == tok_in.key)) tok_next.other_at = 1'b1;
    // track nearest idle car and whether a lower address ties at that distance
    if (valid && dst == FLOOR_NONE) begin
      if (d < tok_in.dmin) begin
        tok_next.dmin = d;
        tok_next.tie  = lower;
      end else if (d == tok_in.dmin) begin
        tok_next.tie = tok_in.tie | lower;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (commit.we && commit.idx == cell_index) begin
      if (commit.cmd == CMD_ADD) begin
        valid <= 1'b1;
      end else if (commit.cmd == CMD_REMOVE) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.we && commit.idx == cell_index) begin
      case (commit.cmd)
        CMD_ADD: begin
          addr <= commit.key;
          loc  <= commit.fv;
          dst  <= FLOOR_NONE;
        end
        CMD_SET_LOC: begin
          loc <= commit.fv;
        end
        CMD_SET_DST: begin
          dst <= commit.fv;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire
